FILE: rtl/tsm_pkg.sv
// tsm_pkg: shared constants, widths and command/status types of the top-k merge
// used by tsm_ctrl, tsm_dp and topk_score_merge; no dependencies
`timescale 1ns / 1ps

package tsm_pkg;

  // table sizing
  localparam int MAX_KEEP = 64;
  localparam int DEPTH    = (MAX_KEEP < 64) ? MAX_KEEP : 64;
  localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W    = $clog2(DEPTH + 1);

  // field widths
  localparam int ID_W     = 32;
  localparam int SCORE_W  = 32;
  localparam int ENTRY_W  = ID_W + SCORE_W;
  localparam int RANK_W   = 6;
  localparam int KEEP_W   = 7;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = KEEP_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_METRIC_MODE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEEP_COUNT  = 1'd1;

  // reset values of the registers
  localparam logic              METRIC_RESET = 1'b1;
  localparam logic [KEEP_W-1:0] KEEP_RESET   = 7'd10;

  // request types
  localparam logic REQ_ADD    = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic load;         // latch request, snapshot count, set index
    logic wr_shift;     // move the read entry one slot down
    logic wr_new_next;  // write new hit below the read entry
    logic wr_new_zero;  // write new hit at the head
    logic idx_dec;
    logic idx_inc;
    logic fill_ins;     // count the inserted hit
    logic emit;         // present the read entry as a result
    logic emit_empty;   // present the empty result
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic n_zero;       // no hits held (live, from fill count)
    logic better;       // new hit beats the read entry
    logic idx_zero;
    logic drain_last;   // index is the final kept entry
  } status_t;

endpackage

FILE: rtl/tsm_ram.sv
// tsm_ram: generic simple dual-port ram, one write and one registered read per cycle
// no dependencies
`timescale 1ns / 1ps

module tsm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

FILE: rtl/tsm_ctrl.sv
// tsm_ctrl: sequencer for insertion scan and drain of the ranked table
// depends on tsm_pkg
`timescale 1ns / 1ps

module tsm_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_req_type,
  input  tsm_pkg::status_t  sts,
  output tsm_pkg::cmd_t     cmd,
  output logic              busy
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_WR_HEAD,
    ST_DR_RD,
    ST_DR_EMIT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign busy = (state_r != ST_IDLE);

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (in_req_type == tsm_pkg::REQ_ADD) begin
            state_nxt = sts.n_zero ? ST_WR_HEAD : ST_SCAN_RD;
          end else if (sts.n_zero) begin
            cmd.emit_empty = 1'b1;
          end else begin
            state_nxt = ST_DR_RD;
          end
        end
      end
      ST_SCAN_RD: begin
        state_nxt = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        if (sts.better) begin
          cmd.wr_shift = 1'b1;
          if (sts.idx_zero) begin
            state_nxt = ST_WR_HEAD;
          end else begin
            cmd.idx_dec = 1'b1;
            state_nxt   = ST_SCAN_RD;
          end
        end else begin
          cmd.wr_new_next = 1'b1;
          cmd.fill_ins    = 1'b1;
          state_nxt       = ST_IDLE;
        end
      end
      ST_WR_HEAD: begin
        cmd.wr_new_zero = 1'b1;
        cmd.fill_ins    = 1'b1;
        state_nxt       = ST_IDLE;
      end
      ST_DR_RD: begin
        state_nxt = ST_DR_EMIT;
      end
      ST_DR_EMIT: begin
        cmd.emit    = 1'b1;
        cmd.idx_inc = 1'b1;
        state_nxt   = sts.drain_last ? ST_IDLE : ST_DR_RD;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: rtl/tsm_dp.sv
// tsm_dp: datapath with config registers, ranked table ram, index and fill count,
// score compare and result registers; depends on tsm_pkg and tsm_ram
`timescale 1ns / 1ps

module tsm_dp (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  tsm_pkg::cmd_t                         cmd,
  output tsm_pkg::status_t                      sts,
  input  logic                                  cfg_we,
  input  logic [tsm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tsm_pkg::CFG_W-1:0]             cfg_wdata,
  input  logic                                  in_req_type,
  input  logic [tsm_pkg::ID_W-1:0]              in_block_offset,
  input  logic [tsm_pkg::ID_W-1:0]              in_local_id,
  input  logic signed [tsm_pkg::SCORE_W-1:0]    in_hit_score,
  output logic                                  out_valid,
  output logic [tsm_pkg::ID_W-1:0]              out_doc_id,
  output logic signed [tsm_pkg::SCORE_W-1:0]    out_score,
  output logic [tsm_pkg::RANK_W-1:0]            out_rank,
  output logic                                  out_is_empty,
  output logic                                  out_last
);

  logic                               metric_mode_r;
  logic [tsm_pkg::KEEP_W-1:0]         keep_count_r;
  logic [tsm_pkg::CNT_W-1:0]          fill_r;
  logic [tsm_pkg::CNT_W-1:0]          n_r;
  logic [tsm_pkg::ADDR_W-1:0]         idx_r;
  logic [tsm_pkg::ID_W-1:0]           hit_id_r;
  logic signed [tsm_pkg::SCORE_W-1:0] hit_score_r;

  logic                               out_valid_r;
  logic [tsm_pkg::ID_W-1:0]           out_doc_id_r;
  logic signed [tsm_pkg::SCORE_W-1:0] out_score_r;
  logic [tsm_pkg::RANK_W-1:0]         out_rank_r;
  logic                               out_is_empty_r;
  logic                               out_last_r;

  logic [tsm_pkg::CNT_W-1:0]          k_lim;
  logic [tsm_pkg::CNT_W-1:0]          n_now;
  logic [tsm_pkg::CNT_W-1:0]          n_now_m1;
  logic [tsm_pkg::CNT_W-1:0]          nxt_pos;
  logic                               shift_ok;

  logic                               ram_we;
  logic [tsm_pkg::ADDR_W-1:0]         ram_waddr;
  logic [tsm_pkg::ENTRY_W-1:0]        ram_wdata;
  logic [tsm_pkg::ENTRY_W-1:0]        ram_rdata;
  logic [tsm_pkg::ID_W-1:0]           rd_id;
  logic signed [tsm_pkg::SCORE_W-1:0] rd_score;

  // effective keep limit: zero reads as one, clipped to table depth
  always_comb begin
    if (keep_count_r == '0) begin
      k_lim = tsm_pkg::CNT_W'(1);
    end else if (keep_count_r > tsm_pkg::KEEP_W'(tsm_pkg::DEPTH)) begin
      k_lim = tsm_pkg::CNT_W'(tsm_pkg::DEPTH);
    end else begin
      k_lim = tsm_pkg::CNT_W'(keep_count_r);
    end
  end

  // held hits, trimmed to the current limit
  assign n_now    = (fill_r > k_lim) ? k_lim : fill_r;
  assign n_now_m1 = n_now - tsm_pkg::CNT_W'(1);

  // table entry read at idx_r
  assign rd_id    = ram_rdata[tsm_pkg::ENTRY_W-1:tsm_pkg::SCORE_W];
  assign rd_score = ram_rdata[tsm_pkg::SCORE_W-1:0];

  // slot below the read entry, dropped when past the limit
  assign nxt_pos  = tsm_pkg::CNT_W'(idx_r) + tsm_pkg::CNT_W'(1);
  assign shift_ok = (nxt_pos < k_lim);

  // status toward the controller
  always_comb begin
    sts.n_zero     = (n_now == '0);
    sts.better     = metric_mode_r ? (hit_score_r < rd_score) : (hit_score_r > rd_score);
    sts.idx_zero   = (idx_r == '0);
    sts.drain_last = (nxt_pos == n_r);
  end

  // table write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = nxt_pos[tsm_pkg::ADDR_W-1:0];
    ram_wdata = {hit_id_r, hit_score_r};
    if (cmd.wr_shift) begin
      ram_we    = shift_ok;
      ram_wdata = ram_rdata;
    end else if (cmd.wr_new_next) begin
      ram_we    = shift_ok;
    end else if (cmd.wr_new_zero) begin
      ram_we    = 1'b1;
      ram_waddr = '0;
    end
  end

  tsm_ram #(
    .WIDTH (tsm_pkg::ENTRY_W),
    .DEPTH (tsm_pkg::DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (idx_r),
    .rdata_r (ram_rdata)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      metric_mode_r <= tsm_pkg::METRIC_RESET;
      keep_count_r  <= tsm_pkg::KEEP_RESET;
    end else if (cfg_we) begin
      if (cfg_index == tsm_pkg::REG_METRIC_MODE) begin
        metric_mode_r <= cfg_wdata[0];
      end
      if (cfg_index == tsm_pkg::REG_KEEP_COUNT) begin
        keep_count_r <= cfg_wdata[tsm_pkg::KEEP_W-1:0];
      end
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.load) begin
      fill_r <= (in_req_type == tsm_pkg::REQ_FINISH) ? '0 : n_now;
    end else if (cmd.fill_ins) begin
      fill_r <= (n_r < k_lim) ? (n_r + tsm_pkg::CNT_W'(1)) : n_r;
    end
  end

  // request latch, snapshot count and walk index
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      hit_id_r    <= in_block_offset + in_local_id;
      hit_score_r <= in_hit_score;
      n_r         <= n_now;
      idx_r       <= (in_req_type == tsm_pkg::REQ_FINISH) ? '0
                     : n_now_m1[tsm_pkg::ADDR_W-1:0];
    end else if (cmd.idx_dec) begin
      idx_r <= idx_r - tsm_pkg::ADDR_W'(1);
    end else if (cmd.idx_inc) begin
      idx_r <= idx_r + tsm_pkg::ADDR_W'(1);
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit | cmd.emit_empty;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_doc_id_r   <= rd_id;
      out_score_r    <= rd_score;
      out_rank_r     <= tsm_pkg::RANK_W'(idx_r);
      out_is_empty_r <= 1'b0;
      out_last_r     <= sts.drain_last;
    end else if (cmd.emit_empty) begin
      out_doc_id_r   <= '0;
      out_score_r    <= '0;
      out_rank_r     <= '0;
      out_is_empty_r <= 1'b1;
      out_last_r     <= 1'b1;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_doc_id   = out_doc_id_r;
  assign out_score    = out_score_r;
  assign out_rank     = out_rank_r;
  assign out_is_empty = out_is_empty_r;
  assign out_last     = out_last_r;

endmodule

FILE: rtl/topk_score_merge.sv
// topk_score_merge: top level, streaming top-k merge of search hits
// depends on tsm_pkg, tsm_ctrl, tsm_dp (which holds tsm_ram)
// add request: busy while the hit is compared with kept entries from the last one upward,
//   each a ram read then a compare, until it stops or passes all (an empty table: head write only)
// finish request: busy while the kept entries are drained in rank order, each result
//   after a ram read then the result register; an empty drain shows its result next cycle
// reset (synchronous, rst_n low): table empty, metric_mode 1, keep_count 10, no result;
//   results go out without stall, the receiver cannot hold them off
`timescale 1ns / 1ps

module topk_score_merge (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  start,
  output logic                                  busy,
  input  logic                                  in_req_type,
  input  logic [tsm_pkg::ID_W-1:0]              in_block_offset,
  input  logic [tsm_pkg::ID_W-1:0]              in_local_id,
  input  logic signed [tsm_pkg::SCORE_W-1:0]    in_hit_score,
  output logic                                  out_valid,
  output logic [tsm_pkg::ID_W-1:0]              out_doc_id,
  output logic signed [tsm_pkg::SCORE_W-1:0]    out_score,
  output logic [tsm_pkg::RANK_W-1:0]            out_rank,
  output logic                                  out_is_empty,
  output logic                                  out_last,
  input  logic                                  cfg_we,
  input  logic [tsm_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [tsm_pkg::CFG_W-1:0]             cfg_wdata
);

  tsm_pkg::cmd_t    cmd;
  tsm_pkg::status_t sts;
  logic             ctrl_busy;

  // request accepted only while idle
  tsm_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start & ~ctrl_busy),
    .in_req_type (in_req_type),
    .sts         (sts),
    .cmd         (cmd),
    .busy        (ctrl_busy)
  );

  tsm_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_req_type     (in_req_type),
    .in_block_offset (in_block_offset),
    .in_local_id     (in_local_id),
    .in_hit_score    (in_hit_score),
    .out_valid       (out_valid),
    .out_doc_id      (out_doc_id),
    .out_score       (out_score),
    .out_rank        (out_rank),
    .out_is_empty    (out_is_empty),
    .out_last        (out_last)
  );

  assign busy = ctrl_busy;

endmodule

FILE: rtl/tsm_checker.sv
// tsm_checker: port-level assertions for topk_score_merge, bound to the top level
// depends on tsm_pkg and topk_score_merge
`timescale 1ns / 1ps

module tsm_checker (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic                               busy,
  input  logic                               in_req_type,
  input  logic                               out_valid,
  input  logic [tsm_pkg::RANK_W-1:0]         out_rank,
  input  logic                               out_is_empty,
  input  logic                               out_last
);

  // an empty drain is a single result
  a_empty_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_is_empty |-> out_last && (out_rank == '0))
    else $error("empty result not marked last at rank zero");

  // mid-drain results come while the block is still busy
  a_mid_drain_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("non-final result while idle");

  // results of one drain are spaced by the table read
  a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> !out_valid)
    else $error("back-to-back results within a drain");

  // an add request produces no result
  a_add_silent: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_req_type == tsm_pkg::REQ_ADD) |=> !out_valid)
    else $error("result after an add request");

endmodule

bind topk_score_merge tsm_checker u_tsm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .in_req_type  (in_req_type),
  .out_valid    (out_valid),
  .out_rank     (out_rank),
  .out_is_empty (out_is_empty),
  .out_last     (out_last)
);
